[sv/waypoint_path_follower_core_macros.svh]
// Assertion macros shared by the waypoint path follower RTL.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef WAYPOINT_PATH_FOLLOWER_CORE_MACROS_SVH
`define WAYPOINT_PATH_FOLLOWER_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define WPF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("waypoint path follower assertion failed");

// The consequent holds in the cycle after the antecedent.
`define WPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("waypoint path follower assertion failed");

`endif

[sv/wpf_pkg.sv]
// Package for the waypoint path follower: sizes, codes and the sequencer states.
// Used by waypoint_path_follower_core; depends on nothing.
`default_nettype none
package wpf_pkg;
	localparam int WP_DEPTH = 64;
	localparam int WP_AW    = $clog2(WP_DEPTH);
	localparam int DIV_STEPS  = 24;
	localparam int SQRT_STEPS = 12;
	localparam logic [15:0] TURN_ONE = 16'd16384;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SPEED    = 3'd0,
		REG_ADVANCE  = 3'd1,
		REG_FINISH   = 3'd2,
		REG_DEADBAND = 3'd3,
		REG_MINTURN  = 3'd4,
		REG_PATHLEN  = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_DX, ST_SQX, ST_SQY, ST_CMP,
		ST_MUL1, ST_MUL2, ST_DIV, ST_SQRT, ST_RES
	} state_t;
endpackage
`default_nettype wire

[sv/waypoint_path_follower_core.sv]
// Waypoint path follower: waypoint table, target scan, bit-serial velocity
// normalization and turn-rate shaping. Depends on wpf_pkg and the macro header.
// Start and load items go straight from acceptance to the result state. A tick scans
// waypoints one by one (memory read, difference, two squares, compare), then works out
// the two velocity components in turn (two multiplies, a 24-step divider, a 12-step
// root) before the result state; at zero distance it skips the velocity work.
// One item is in work at a time; a stalled result holds it.
// arst_n clears the sequencer, target and output valid and sets the configuration registers to defaults; not the table.
`default_nettype none
`include "waypoint_path_follower_core_macros.svh"
module waypoint_path_follower_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // slot[5:0], x_mm[21:6], y_mm[37:22], angle[53:38]
	input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // vel_x[12:0], vel_y[25:13], turn_rate[41:26],
	                                        // target_index[47:42]
	output logic [0:0]       m_axis_tuser   // finished[0]
);
	import wpf_pkg::*;

	// Configuration registers.
	logic [11:0] speed_q;
	logic [9:0]  adv_q, fin_q;
	logic [14:0] deadband_q, minturn_q;
	logic [6:0]  pathlen_q;

	logic cfg_wr;
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= 12'd1500;
			adv_q      <= 10'd80;
			fin_q      <= 10'd50;
			deadband_q <= 15'd910;
			minturn_q  <= 15'd819;
			pathlen_q  <= 7'd1;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_SPEED:    speed_q    <= pwdata[11:0];
				REG_ADVANCE:  adv_q      <= pwdata[9:0];
				REG_FINISH:   fin_q      <= pwdata[9:0];
				REG_DEADBAND: deadband_q <= pwdata[14:0];
				REG_MINTURN:  minturn_q  <= pwdata[14:0];
				REG_PATHLEN:  pathlen_q  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_SPEED:    prdata = {20'd0, speed_q};
			REG_ADVANCE:  prdata = {22'd0, adv_q};
			REG_FINISH:   prdata = {22'd0, fin_q};
			REG_DEADBAND: prdata = {17'd0, deadband_q};
			REG_MINTURN:  prdata = {17'd0, minturn_q};
			REG_PATHLEN:  prdata = {25'd0, pathlen_q};
			default:      prdata = 32'd0;
		endcase
	end

	// Input fields.
	logic [WP_AW-1:0]   in_slot;
	logic signed [15:0] in_x, in_y;
	logic [15:0]        in_angle;
	cmd_t               in_cmd;
	assign in_slot  = s_axis_tdata[5:0];
	assign in_x     = s_axis_tdata[21:6];
	assign in_y     = s_axis_tdata[37:22];
	assign in_angle = s_axis_tdata[53:38];
	assign in_cmd   = cmd_t'(s_axis_tuser);

	state_t state_q, state_d;
	logic   in_fire, out_free;
	assign in_fire  = s_axis_tvalid & s_axis_tready;
	assign out_free = ~m_axis_tvalid | m_axis_tready;

	// Waypoint memory: one entry holds heading, y and x; read data registered.
	logic [47:0] mem_q [WP_DEPTH];
	logic [47:0] rd_q;
	logic [WP_AW-1:0] idx_q, last_q, cur_q;

	always_ff @(posedge clk) begin
		if (in_fire && in_cmd == CMD_LOAD)
			mem_q[in_slot] <= {in_angle, in_y, in_x};
		rd_q <= mem_q[idx_q];
	end

	// Last index in use: path length held to one through the table depth.
	logic [WP_AW-1:0] last_d;
	always_comb begin
		if (pathlen_q == 7'd0)
			last_d = '0;
		else if (pathlen_q > 7'(WP_DEPTH))
			last_d = WP_AW'(WP_DEPTH - 1);
		else
			last_d = WP_AW'(pathlen_q - 7'd1);
	end

	// Tick datapath registers.
	logic signed [15:0] x_q, y_q;
	logic [15:0]        ang_q, hd_q;
	logic signed [16:0] dx_q, dy_q;
	logic [32:0]        dxsq_q;
	logic [33:0]        d2_q;
	logic [19:0]        adv2_q, fin2_q;
	logic               tick_q, comp_q;
	logic [27:0]        p_q;
	logic [33:0]        drem_q;
	logic [23:0]        num_q;
	logic [13:0]        srem_q;
	logic [11:0]        root_q;
	logic [4:0]         cnt_q;
	logic signed [12:0] vx_q, vy_q;

	// Scan compare: stop at the first waypoint beyond the advance distance or at the last.
	logic hit, d2_zero;
	assign hit     = (d2_q > {14'd0, adv2_q}) || (idx_q == last_q);
	assign d2_zero = (d2_q == '0);

	// Component under work and its magnitude.
	logic signed [16:0] comp;
	logic [16:0]        comp_abs;
	logic [55:0]        nsq;
	assign comp     = comp_q ? dy_q : dx_q;
	assign comp_abs = comp[16] ? 17'(-comp) : 17'(comp);
	assign nsq      = p_q * p_q;

	// One restoring divider step: the quotient is known to fit in 24 bits.
	logic [34:0] dtry;
	logic        dge;
	assign dtry = {drem_q, num_q[23]};
	assign dge  = dtry >= {1'b0, d2_q};

	// One square-root step, two radicand bits per cycle.
	logic [15:0] stry, strial;
	logic        sge;
	logic [11:0] root_d;
	assign stry   = {srem_q, num_q[23:22]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sge    = stry >= strial;
	assign root_d = {root_q[10:0], sge};

	logic signed [12:0] vel_d;
	assign vel_d = comp[16] ? -13'(root_d) : 13'(root_d);

	// Turn rate from the wrapped heading error.
	logic signed [15:0] herr;
	logic [15:0]        herr_abs, frac_min, frac;
	logic signed [15:0] turn;
	logic               fin_flag;
	always_comb begin
		herr     = signed'(hd_q - ang_q);
		herr_abs = herr[15] ? 16'(-herr) : 16'(herr);
		frac_min = {1'b0, herr_abs[15:1]};
		if (frac_min < {1'b0, minturn_q})
			frac_min = {1'b0, minturn_q};
		frac = (frac_min > TURN_ONE) ? TURN_ONE : frac_min;
		if (herr_abs > {1'b0, deadband_q})
			turn = herr[15] ? -signed'(frac) : signed'(frac);
		else
			turn = '0;
		fin_flag = (cur_q == last_q) && (d2_q < {14'd0, fin2_q});
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_d = (in_cmd == CMD_TICK) ? ST_RD : ST_RES;
			ST_RD:   state_d = ST_DX;
			ST_DX:   state_d = ST_SQX;
			ST_SQX:  state_d = ST_SQY;
			ST_SQY:  state_d = ST_CMP;
			ST_CMP: begin
				if (!hit)
					state_d = ST_RD;
				else
					state_d = d2_zero ? ST_RES : ST_MUL1;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DIV;
			ST_DIV:  if (cnt_q == 5'(DIV_STEPS - 1)) state_d = ST_SQRT;
			ST_SQRT: begin
				if (cnt_q == 5'(SQRT_STEPS - 1))
					state_d = comp_q ? ST_RES : ST_MUL1;
			end
			ST_RES:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cur_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && in_cmd == CMD_START)
				cur_q <= '0;
			if (state_q == ST_CMP && hit)
				cur_q <= idx_q;
			if (state_q == ST_RES && out_free)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					tick_q <= (in_cmd == CMD_TICK);
					x_q    <= in_x;
					y_q    <= in_y;
					ang_q  <= in_angle;
					adv2_q <= 20'(adv_q) * 20'(adv_q);
					fin2_q <= 20'(fin_q) * 20'(fin_q);
					last_q <= last_d;
					idx_q  <= (cur_q > last_d) ? last_d : cur_q;
					vx_q   <= '0;
					vy_q   <= '0;
					comp_q <= 1'b0;
				end
			end
			ST_DX: begin
				dx_q <= 17'(signed'(rd_q[15:0])) - 17'(x_q);
				dy_q <= 17'(signed'(rd_q[31:16])) - 17'(y_q);
				hd_q <= rd_q[47:32];
			end
			ST_SQX: dxsq_q <= 33'(unsigned'(34'(dx_q) * 34'(dx_q)));
			ST_SQY: d2_q   <= {1'b0, dxsq_q} + 34'(unsigned'(34'(dy_q) * 34'(dy_q)));
			ST_CMP: if (!hit) idx_q <= idx_q + 1'b1;
			ST_MUL1: p_q <= 28'(speed_q * comp_abs);
			ST_MUL2: begin
				drem_q <= {2'b00, nsq[55:24]};
				num_q  <= nsq[23:0];
				cnt_q  <= '0;
			end
			ST_DIV: begin
				drem_q <= dge ? 34'(dtry - {1'b0, d2_q}) : dtry[33:0];
				num_q  <= {num_q[22:0], dge};
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					cnt_q  <= '0;
					srem_q <= '0;
					root_q <= '0;
				end else
					cnt_q <= cnt_q + 1'b1;
			end
			ST_SQRT: begin
				srem_q <= sge ? 14'(stry - strial) : stry[13:0];
				root_q <= root_d;
				num_q  <= {num_q[21:0], 2'b00};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == 5'(SQRT_STEPS - 1)) begin
					if (comp_q) vy_q <= vel_d;
					else        vx_q <= vel_d;
					comp_q <= 1'b1;
				end
			end
			ST_RES: begin
				if (out_free) begin
					if (tick_q) begin
						m_axis_tdata <= {cur_q, turn, vy_q, vx_q};
						m_axis_tuser <= fin_flag;
					end else begin
						m_axis_tdata <= {cur_q, 42'd0};
						m_axis_tuser <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	// The scan never steps past the last waypoint in use.
	`WPF_ASSERT_NOW(a_scan_bound, state_q == ST_CMP && !hit, idx_q != last_q)
	// A velocity magnitude never exceeds the configured speed.
	`WPF_ASSERT_NOW(a_root_bound, state_q == ST_SQRT, root_q <= speed_q)
	// The root unit hands over to the next component or to the result.
	`WPF_ASSERT_NEXT(a_sqrt_exit, state_q == ST_SQRT && cnt_q == 5'(SQRT_STEPS - 1),
		state_q == ST_MUL1 || state_q == ST_RES)
	// Finished is only reported while steering at the last waypoint.
	`WPF_ASSERT_NOW(a_fin_last, m_axis_tvalid && m_axis_tuser[0],
		m_axis_tdata[47:42] == last_q)
endmodule
`default_nettype wire
